// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round helpers for the SHA-1 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned RING_WORDS   = 16;
    localparam int unsigned ROUNDS       = 80;

    // ring slot that receives the high length word
    localparam logic [3:0] LEN_SLOT      = 4'd14;
    localparam logic [3:0] LAST_SLOT     = 4'd15;
    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [2:0] LAST_INDEX    = 3'd4;
    localparam logic [2:0] FULL_BYTES    = 3'd4;

    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hEFCD_AB89;
    localparam logic [31:0] IV2 = 32'h98BA_DCFE;
    localparam logic [31:0] IV3 = 32'h1032_5476;
    localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

    localparam logic [31:0] K0 = 32'h5A82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hCA62_C1D6;

    localparam logic [31:0] PAD_MARKER_WORD = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARKER,
        PAD_ZERO,
        PAD_LEN_HI,
        PAD_LEN_LO
    } t_pad_sel;

    typedef struct packed {
        logic       push_in;    // take the input word into the ring
        logic       push_pad;   // take a padding word into the ring
        t_pad_sel   pad_sel;
        logic       load_vars;  // a..e <= chaining value
        logic       round_en;
        logic [6:0] round_idx;
        logic       fold;       // chaining value += a..e
        logic       clear;      // back to the initial state
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] word_pos;
        logic       full_word;  // input word carries four bytes
    } t_dp_stat;

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = K0;
        end else if (t < 7'd40) begin
            k = K1;
        end else if (t < 7'd60) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_datapath.sv =====
// ----------------------------------------------------------------------------
// sha1_datapath
// Chaining value, schedule shift line, working variables and length counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sha1_pkg::t_dp_cmd  i_cmd,
    output sha1_pkg::t_dp_stat      o_stat,
    input  wire logic [31:0]        i_message_word,
    input  wire logic [2:0]         i_byte_count,
    input  wire logic               i_last_word,
    output logic [31:0]             o_digest_word
);

    logic [31:0] r_chain [sha1_pkg::DIGEST_WORDS];
    logic [31:0] r_ring  [sha1_pkg::RING_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [63:0] r_len;
    logic [3:0]  r_pos;

    logic [2:0]  eff_count;
    logic [31:0] in_word;
    logic [31:0] pad_word;
    logic [31:0] push_word;
    logic [31:0] expand;
    logic [31:0] w_t;
    logic [31:0] tmp;

    // counts above four, and every word but the last, carry four bytes
    assign eff_count = (!i_last_word || i_byte_count > sha1_pkg::FULL_BYTES) ?
                       sha1_pkg::FULL_BYTES : i_byte_count;

    // clear unused bytes and, in a short last word, place the 0x80 marker right after the data
    always_comb begin
        case (eff_count)
            3'd0:    in_word = sha1_pkg::PAD_MARKER_WORD;
            3'd1:    in_word = {i_message_word[31:24], 24'h80_0000};
            3'd2:    in_word = {i_message_word[31:16], 16'h8000};
            3'd3:    in_word = {i_message_word[31:8], 8'h80};
            default: in_word = i_message_word;
        endcase
    end

    always_comb begin
        unique case (i_cmd.pad_sel)
            sha1_pkg::PAD_MARKER: pad_word = sha1_pkg::PAD_MARKER_WORD;
            sha1_pkg::PAD_ZERO:   pad_word = 32'd0;
            sha1_pkg::PAD_LEN_HI: pad_word = r_len[63:32];
            sha1_pkg::PAD_LEN_LO: pad_word = r_len[31:0];
            default:              pad_word = 32'd0;
        endcase
    end

    assign push_word = i_cmd.push_in ? in_word : pad_word;

    // r_ring[0] is W[t-16]; the first 16 rounds rotate the loaded block
    assign expand = r_ring[13] ^ r_ring[8] ^ r_ring[2] ^ r_ring[0];
    assign w_t    = (i_cmd.round_idx < 7'd16) ? r_ring[0] : {expand[30:0], expand[31]};

    assign tmp = {r_a[26:0], r_a[31:27]}
               + sha1_pkg::round_f(i_cmd.round_idx, r_b, r_c, r_d)
               + r_e + sha1_pkg::round_k(i_cmd.round_idx) + w_t;

    // schedule shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_in || i_cmd.push_pad || i_cmd.round_en) begin
            for (int i = 0; i < sha1_pkg::RING_WORDS - 1; i++) begin
                r_ring[i] <= r_ring[i + 1];
            end
            r_ring[sha1_pkg::RING_WORDS - 1] <= i_cmd.round_en ? w_t : push_word;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round_en) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_chain[0] <= sha1_pkg::IV0;
            r_chain[1] <= sha1_pkg::IV1;
            r_chain[2] <= sha1_pkg::IV2;
            r_chain[3] <= sha1_pkg::IV3;
            r_chain[4] <= sha1_pkg::IV4;
            r_len      <= 64'd0;
            r_pos      <= 4'd0;
        end else begin
            if (i_cmd.fold) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.push_in) begin
                r_len <= r_len + {58'd0, eff_count, 3'd0};
            end
            if (i_cmd.push_in || i_cmd.push_pad) begin
                r_pos <= r_pos + 4'd1;
            end
        end
    end

    always_comb begin
        case (i_cmd.out_idx)
            3'd0:    o_digest_word = r_chain[0];
            3'd1:    o_digest_word = r_chain[1];
            3'd2:    o_digest_word = r_chain[2];
            3'd3:    o_digest_word = r_chain[3];
            3'd4:    o_digest_word = r_chain[4];
            default: o_digest_word = 32'd0;
        endcase
    end

    assign o_stat.word_pos  = r_pos;
    assign o_stat.full_word = (eff_count == sha1_pkg::FULL_BYTES);

endmodule

`default_nettype wire

// ===== rtl/core/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: word intake, 80-round loop, padding and digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_last_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_word_index,
    output logic                    o_last_result,
    output sha1_pkg::t_dp_cmd       o_cmd,
    input  wire sha1_pkg::t_dp_stat i_stat
);

    sha1_pkg::t_state r_state, n_state;
    logic [6:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_padding, n_padding;
    logic       r_need_marker, n_need_marker;
    logic       r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sha1_pkg::ST_IDLE;
            r_round       <= 7'd0;
            r_idx         <= 3'd0;
            r_padding     <= 1'b0;
            r_need_marker <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_round       <= n_round;
            r_idx         <= n_idx;
            r_padding     <= n_padding;
            r_need_marker <= n_need_marker;
            r_done        <= n_done;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_round       = r_round;
        n_idx         = r_idx;
        n_padding     = r_padding;
        n_need_marker = r_need_marker;
        n_done        = r_done;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        o_cmd.pad_sel   = sha1_pkg::PAD_ZERO;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_idx;

        unique case (r_state)
            sha1_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push_in = 1'b1;
                    if (i_last_word) begin
                        n_padding     = 1'b1;
                        n_need_marker = i_stat.full_word;
                    end
                    if (i_stat.word_pos == sha1_pkg::LAST_SLOT) begin
                        o_cmd.load_vars = 1'b1;
                        n_round         = 7'd0;
                        n_state         = sha1_pkg::ST_ROUNDS;
                    end else if (i_last_word) begin
                        n_state = sha1_pkg::ST_PAD;
                    end
                end
            end
            sha1_pkg::ST_ROUNDS: begin
                o_cmd.round_en = 1'b1;
                n_round        = r_round + 7'd1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = 7'd0;
                    n_state = sha1_pkg::ST_FOLD;
                end
            end
            sha1_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_done) begin
                    n_idx   = 3'd0;
                    n_state = sha1_pkg::ST_OUT;
                end else if (r_padding) begin
                    n_state = sha1_pkg::ST_PAD;
                end else begin
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            sha1_pkg::ST_PAD: begin
                o_cmd.push_pad = 1'b1;
                // the low length word follows the high one in the same block
                if (r_need_marker) begin
                    o_cmd.pad_sel = sha1_pkg::PAD_MARKER;
                    n_need_marker = 1'b0;
                end else if (i_stat.word_pos == sha1_pkg::LEN_SLOT) begin
                    o_cmd.pad_sel = sha1_pkg::PAD_LEN_HI;
                    n_done        = 1'b1;
                end else if (r_done) begin
                    o_cmd.pad_sel = sha1_pkg::PAD_LEN_LO;
                end
                if (i_stat.word_pos == sha1_pkg::LAST_SLOT) begin
                    o_cmd.load_vars = 1'b1;
                    n_round         = 7'd0;
                    n_state         = sha1_pkg::ST_ROUNDS;
                end
            end
            sha1_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == sha1_pkg::LAST_INDEX) begin
                        o_cmd.clear   = 1'b1;
                        n_idx         = 3'd0;
                        n_padding     = 1'b0;
                        n_need_marker = 1'b0;
                        n_done        = 1'b0;
                        n_state       = sha1_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_word_index  = r_idx;
    assign o_last_result = (r_idx == sha1_pkg::LAST_INDEX);

endmodule

`default_nettype wire

// ===== rtl/core/sha1_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_hasher
// Streaming SHA-1 engine over 32-bit big-endian message words.
// ----------------------------------------------------------------------------
// Feed the message as 32-bit big-endian words, valid bytes in the high lanes,
// with i_byte_count giving the valid bytes (only the final word may carry
// fewer than four) and i_last_word marking the end of the message. An empty
// message is a single last word with a byte count of zero. A word is taken
// whenever o_in_ready is high. After the word that completes a 64-byte block
// the input holds off while the block is hashed (80 rounds at one round per
// cycle in the shared round unit, then a fold of a..e into the chaining
// value) and accepts words again once the fold is done. The last word
// additionally triggers padding (the final pad word of a block also loading
// a..e) and one or two blocks of 80 rounds plus a fold, then the digest comes
// out as a run of five items, H0 first, with o_last_result on the fifth. The
// output waits as long as needed for i_out_ready; the next message is
// accepted once the fifth digest item has been taken, and the engine starts
// again from the standard initial chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_message_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_result
);

    sha1_pkg::t_dp_cmd  cmd;
    sha1_pkg::t_dp_stat stat;

    // sequencer: owns the state, round counter and digest index
    sha1_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word_index  (o_word_index),
        .o_last_result (o_last_result),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // datapath: schedule line, round unit, chaining value and length
    sha1_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_digest_word  (o_digest_word)
    );

endmodule

`default_nettype wire
